// ===== rtl/core/ring_priority_queue_linear_scan_unit_macros.svh =====
// Assertion macros used by the ring priority queue sequencer.
`ifndef RING_PRIORITY_QUEUE_LINEAR_SCAN_UNIT_MACROS_SVH
`define RING_PRIORITY_QUEUE_LINEAR_SCAN_UNIT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define RPQ_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rpq: invariant violated");

// Trigger in one cycle implies a consequence in the next.
`define RPQ_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("rpq: sequence violated");

`endif

// ===== rtl/core/rpq_pkg.sv =====
// Package: widths, codes, entry/request/result types and ring helpers for the queue.
`timescale 1ns / 1ps
package rpq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int PRI_W = 16;
  localparam int CFG_W = 5;
  localparam int OCC_W = 5;
  localparam int ENTRY_W = VAL_W + PRI_W;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    REQ_FRONT  = 2'd0,
    REQ_REAR   = 2'd1,
    REQ_REMOVE = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_LAST,
    S_SHIFT,
    S_SHIFT_LAST,
    S_RESP
  } state_t;

  typedef struct packed {
    logic signed [PRI_W-1:0] pri;
    logic signed [VAL_W-1:0] val;
  } entry_t;

  typedef struct packed {
    req_kind_t               kind;
    logic signed [VAL_W-1:0] val;
    logic signed [PRI_W-1:0] pri;
  } req_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] val;
    logic signed [PRI_W-1:0] pri;
    logic [OCC_W-1:0]        occupancy;
  } res_t;

  // Raw capacity register -> slots actually used (0 acts as 1, clamp at DEPTH).
  function automatic logic [CNT_W-1:0] eff_cap(logic [CFG_W-1:0] raw);
    logic [CNT_W-1:0] r;
    if (raw == '0) begin
      r = CNT_W'(1);
    end else if (int'(raw) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(raw);
    end
    return r;
  endfunction

  // Step one slot forward around a ring of cap slots.
  function automatic logic [IDX_W-1:0] ring_inc(logic [IDX_W-1:0] p,
                                                logic [CNT_W-1:0] cap);
    logic [IDX_W-1:0] r;
    if (CNT_W'(p) == cap - CNT_W'(1)) begin
      r = '0;
    end else begin
      r = p + IDX_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/ring_priority_queue_linear_scan_unit.sv =====
// Top level: stream ports, capacity register and output register around the queue sequencer.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  request beat: kind in tuser, value+priority in tdata
//  m_*      out  m_tvalid / m_tready  result beat: status in tuser, value/priority/occupancy
//  cfg_*    in   cfg_valid / cfg_ready  capacity register write (clears the queue)
//
//  Insert: accept with memory write, then hand-off to the output register.
//  Remove of n held entries: a scan that reads each held entry and drains the last read,
//  then, unless the winner is the last entry, a shift of each entry behind the winner
//  with a final write, then the hand-off; paced by the single read port of the slot RAM.
//  Reset: synchronous, queue empty, capacity 16; slot RAM is not cleared.
//  A result waits in the output register while the next beat is taken; the sequencer
//  holds its own result only when that register is still full.
`timescale 1ns / 1ps
module ring_priority_queue_linear_scan_unit
  import rpq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [ENTRY_W-1:0]   s_tdata,   // [31:0] item_value, [47:32] item_priority
  input  logic [1:0]           s_tuser,   // [1:0] req_type
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [55:0]          m_tdata,   // [31:0] removed_value, [47:32] removed_priority,
                                          // [52:48] occupancy, [55:53] zero
  output logic [1:0]           m_tuser,   // [1:0] status
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_data   // queue_capacity
);

  logic [CNT_W-1:0] cap;
  logic             idle;
  logic             req_valid;
  logic             req_ready;
  req_t             req;
  logic             cfg_we;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  res_t             out_res;

  // configuration is taken only between requests and wins over a same-cycle request
  assign cfg_ready = idle;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign req_valid = s_tvalid && !cfg_valid;
  assign s_tready  = req_ready && !cfg_valid;

  assign req = '{kind: req_kind_t'(s_tuser),
                 val:  s_tdata[VAL_W-1:0],
                 pri:  s_tdata[ENTRY_W-1:VAL_W]};

  // store the effective capacity so the ring math never sees 0 or > DEPTH
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= eff_cap(CAP_RESET);
    end else if (cfg_we) begin
      cap <= eff_cap(cfg_data);
    end
  end

  rpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cfg_clear (cfg_we),
    .cap       (cap),
    .idle      (idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: refills in the same cycle the held beat leaves
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.status;
  assign m_tdata = {3'b000, out_res.occupancy, out_res.pri, out_res.val};

endmodule

// ===== rtl/core/rpq_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module rpq_ram #(
  parameter int WIDTH  = 48,
  parameter int WORDS  = 16,
  parameter int ADDR_W = $clog2(WORDS)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rpq_ctrl.sv =====
// Queue sequencer: ring pointers, insert writes, max-priority scan and shift-down pass.
`timescale 1ns / 1ps
`include "ring_priority_queue_linear_scan_unit_macros.svh"
module rpq_ctrl
  import rpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  input  logic             cfg_clear,
  input  logic [CNT_W-1:0] cap,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res
);

  state_t state, state_next;

  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;

  // scan bookkeeping
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] scan_k;
  logic             dv;
  logic             dv_first;
  logic [IDX_W-1:0] dv_pos;
  logic [CNT_W-1:0] dv_k;
  logic [CNT_W-1:0] best_k;
  logic [IDX_W-1:0] best_pos;
  entry_t           best;

  // shift bookkeeping
  logic [IDX_W-1:0] src;
  logic [IDX_W-1:0] dst;
  logic [CNT_W-1:0] sh_k;
  logic             pend;
  logic [IDX_W-1:0] pend_dst;

  // result hold
  status_t                 r_status;
  logic signed [VAL_W-1:0] r_val;
  logic signed [PRI_W-1:0] r_pri;

  // memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  entry_t           rd_entry;

  logic             accept;
  logic [CNT_W-1:0] last_k;
  logic             full;
  logic [IDX_W-1:0] front_pos;
  logic [CNT_W:0]   rear_sum;
  logic [IDX_W-1:0] rear_pos;
  logic             better;
  logic             take;
  logic [CNT_W-1:0] nbest_k;
  logic [IDX_W-1:0] nbest_pos;
  entry_t           nbest;

  rpq_ram #(
    .WIDTH (ENTRY_W),
    .WORDS (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_entry = entry_t'(mem_rdata);
  assign accept   = req_valid && req_ready;
  assign last_k   = count - CNT_W'(1);
  assign full     = count >= cap;

  // slot positions for the two insert kinds; head stays below cap and count never exceeds it
  assign front_pos = (head == '0) ? IDX_W'(cap - CNT_W'(1)) : head - IDX_W'(1);
  assign rear_sum  = {1'b0, CNT_W'(head)} + {1'b0, count};
  assign rear_pos  = (rear_sum >= {1'b0, cap}) ? IDX_W'(rear_sum - {1'b0, cap})
                                               : IDX_W'(rear_sum);

  // strictly better only (higher priority, then higher value), so the entry nearest the front keeps full ties
  assign better = (rd_entry.pri > best.pri) ||
                  ((rd_entry.pri == best.pri) && (rd_entry.val > best.val));
  assign take      = dv && (dv_first || better);
  assign nbest_k   = take ? dv_k : best_k;
  assign nbest_pos = take ? dv_pos : best_pos;
  assign nbest     = take ? rd_entry : best;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.kind == REQ_REMOVE && count != '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (scan_k == last_k) begin
          state_next = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: begin
        if (nbest_k == last_k) begin
          state_next = S_RESP;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sh_k == last_k) begin
          state_next = S_SHIFT_LAST;
        end
      end
      S_SHIFT_LAST: state_next = S_RESP;
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and memory port
  always_comb begin
    req_ready = 1'b0;
    idle      = 1'b0;
    res_valid = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = rd_ptr;
    mem_we    = 1'b0;
    mem_waddr = pend_dst;
    mem_wdata = rd_entry;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        idle      = 1'b1;
        if (accept && !full &&
            (req.kind == REQ_FRONT || req.kind == REQ_REAR)) begin
          mem_we    = 1'b1;
          mem_waddr = (req.kind == REQ_FRONT) ? front_pos : rear_pos;
          mem_wdata = '{pri: req.pri, val: req.val};
        end
      end
      S_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = rd_ptr;
      end
      S_SHIFT: begin
        mem_re    = 1'b1;
        mem_raddr = src;
        mem_we    = pend;
      end
      S_SHIFT_LAST: begin
        mem_we = pend;
      end
      S_RESP: begin
        res_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  assign res = '{status: r_status, val: r_val, pri: r_pri,
                 occupancy: OCC_W'(count)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      dv    <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      // read data is valid the cycle after a scan or shift read
      dv    <= (state == S_SCAN);
      pend  <= (state == S_SHIFT);
      if (cfg_clear) begin
        head  <= '0;
        count <= '0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            r_val    <= '0;
            r_pri    <= '0;
            rd_ptr   <= head;
            scan_k   <= '0;
            case (req.kind)
              REQ_FRONT, REQ_REAR: begin
                if (full) begin
                  r_status <= STAT_FULL;
                end else begin
                  r_status <= STAT_DONE;
                  count <= count + CNT_W'(1);
                  if (req.kind == REQ_FRONT) begin
                    head <= front_pos;
                  end
                end
              end
              REQ_REMOVE: begin
                if (count == '0) begin
                  r_status <= STAT_EMPTY;
                end else begin
                  r_status <= STAT_DONE;
                end
              end
              default: r_status <= STAT_DONE;
            endcase
          end
        end
        S_SCAN: begin
          rd_ptr   <= ring_inc(rd_ptr, cap);
          scan_k   <= scan_k + CNT_W'(1);
          dv_first <= (scan_k == '0);
          dv_pos   <= rd_ptr;
          dv_k     <= scan_k;
          best_k   <= nbest_k;
          best_pos <= nbest_pos;
          best     <= nbest;
        end
        S_SCAN_LAST: begin
          r_val <= nbest.val;
          r_pri <= nbest.pri;
          src   <= ring_inc(nbest_pos, cap);
          dst   <= nbest_pos;
          sh_k  <= nbest_k + CNT_W'(1);
          if (nbest_k == last_k) begin
            count <= count - CNT_W'(1);
          end
        end
        S_SHIFT: begin
          // entry at src lands one slot toward the front on the next cycle
          pend_dst <= dst;
          dst      <= src;
          src      <= ring_inc(src, cap);
          sh_k     <= sh_k + CNT_W'(1);
        end
        S_SHIFT_LAST: begin
          count <= count - CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  `RPQ_ASSERT(a_count_in_cap, count <= cap)
  `RPQ_ASSERT(a_head_in_cap, CNT_W'(head) < cap)
  `RPQ_ASSERT(a_pend_in_shift, !pend || state == S_SHIFT || state == S_SHIFT_LAST)
  `RPQ_ASSERT(a_dv_in_scan, !dv || state == S_SCAN || state == S_SCAN_LAST)
  `RPQ_ASSERT_NEXT(a_remove_scans,
                   accept && req.kind == REQ_REMOVE && count != '0,
                   state == S_SCAN)

endmodule
